// ----- hw/rtl/pcc_pkg.sv -----
// shared widths, sum record type and count saturation for the correlation block
package pcc_pkg;

  // set size and count range
  localparam int MAX_PAIRS  = 256;
  localparam int COUNT_BITS = 10;
  localparam int COUNT_MAX  = (1 << COUNT_BITS) - 1;

  // port field widths
  localparam int IN_W       = 10;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_W      = 16;

  // accumulator widths
  localparam int LOG_PAIRS  = $clog2(MAX_PAIRS);
  localparam int N_W        = $clog2(MAX_PAIRS + 1);
  localparam int S_W        = COUNT_BITS + LOG_PAIRS;
  localparam int Q_W        = 2 * COUNT_BITS + LOG_PAIRS;

  // back end widths: variances and numerator, split halves, shared multiplier
  localparam int V_W        = 2 * S_W;
  localparam int HALF_W     = (V_W + 1) / 2;
  localparam int MUL_W      = (Q_W > HALF_W) ? Q_W : HALF_W;
  localparam int PP_W       = 2 * MUL_W;
  localparam int P_W        = 2 * V_W;

  // result fraction bits, quotient width and residue width
  localparam int QF         = 14;
  localparam int ONE_Q      = 1 << QF;
  localparam int K_W        = QF + 1;
  localparam int BIT_W      = $clog2(K_W + 1);
  localparam int TSH        = 2 * K_W;
  localparam int E_W        = P_W + 2 * (QF + 2) + 2;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // running sums of one set
  typedef struct packed {
    logic [N_W-1:0] n;
    logic [S_W-1:0] sa;
    logic [S_W-1:0] sb;
    logic [Q_W-1:0] sab;
    logic [Q_W-1:0] saa;
    logic [Q_W-1:0] sbb;
  } pcc_sums_t;

  // clamp an incoming count to the count range
  function automatic logic [COUNT_BITS-1:0] sat_count(input logic [IN_W-1:0] v);
    if (32'(v) > 32'(COUNT_MAX)) begin
      sat_count = COUNT_BITS'(COUNT_MAX);
    end else begin
      sat_count = COUNT_BITS'(v);
    end
  endfunction

endpackage

// ----- hw/rtl/pearson_correlation_of_counts.sv -----
// Pearson correlation of two count streams, one result per set of pairs
//
// Input channel: one transfer per element pair, in_tdata carries the two
// counts and in_tlast marks the final pair of a set. Pairs are taken one per
// cycle while in_tready is high; counts above the count range saturate, pairs
// beyond the set limit are dropped, and a tlast on a dropped pair still closes
// the set. Output channel: one transfer per set, out_tdata is the signed Q2.14
// correlation rounded to nearest, out_tuser is 1 when a variance is zero
// (the correlation is then 0).
// From the last pair of a set to out_tvalid: the set is taken from the queue,
// 15 steps run on the shared multiplier, a setup state, the bit-serial quotient
// with a try and a compare state per result bit, and the result register.
// A finished set waits in a two-entry queue, so a new set accumulates while
// the previous one is computed; in_tready drops only while the queue is full,
// i.e. when sets come in faster than the back end finishes them.
// When the receiver stalls, the result is held in out_tdata/out_tuser and the
// back end holds its next result until the register frees.
// Reset clears all sums, the queue and the output valid flag.
module pearson_correlation_of_counts import pcc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // count_a [9:0], count_b [19:10], zero fill
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // correlation [15:0]
  output logic                 out_tuser   // undefined_flag [0]
);

  logic      q_push, q_full, q_pop, q_valid;
  pcc_sums_t q_push_data, q_data;

  // accumulate pairs
  pcc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .count_a   (in_tdata[IN_W-1:0]),
    .count_b   (in_tdata[2*IN_W-1:IN_W]),
    .last_pair (in_tlast),
    .push      (q_push),
    .push_sums (q_push_data),
    .q_full    (q_full)
  );

  // finished sets waiting for the back end
  pcc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_data)
  );

  // correlation per set
  pcc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (q_valid),
    .snap_data  (q_data),
    .snap_pop   (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_corr   (out_tdata),
    .out_flag   (out_tuser)
  );

endmodule

// ----- hw/rtl/pcc_front.sv -----
// front end: takes count pairs, keeps the running sums and hands a finished set to the queue
module pcc_front import pcc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [IN_W-1:0] count_a,
  input  logic [IN_W-1:0] count_b,
  input  logic            last_pair,
  output logic            push,
  output pcc_sums_t       push_sums,
  input  logic            q_full
);

  logic [COUNT_BITS-1:0]   a_sat, b_sat;
  logic [2*COUNT_BITS-1:0] prod_ab, prod_aa, prod_bb;
  logic                    xfer;
  logic                    room;
  pcc_sums_t               sums_r, sums_nxt, sums_upd;

  // a transfer is taken whenever the queue can hold a finished set
  assign in_ready = !q_full;
  assign xfer     = in_valid && in_ready;

  // saturated counts and their products
  assign a_sat   = sat_count(count_a);
  assign b_sat   = sat_count(count_b);
  assign prod_ab = a_sat * b_sat;
  assign prod_aa = a_sat * a_sat;
  assign prod_bb = b_sat * b_sat;

  // pairs past the set limit are dropped
  assign room = sums_r.n < N_W'(MAX_PAIRS);

  // sums with the current pair added
  always_comb begin
    sums_upd = sums_r;
    if (room) begin
      sums_upd.n   = sums_r.n + N_W'(1);
      sums_upd.sa  = sums_r.sa + S_W'(a_sat);
      sums_upd.sb  = sums_r.sb + S_W'(b_sat);
      sums_upd.sab = sums_r.sab + Q_W'(prod_ab);
      sums_upd.saa = sums_r.saa + Q_W'(prod_aa);
      sums_upd.sbb = sums_r.sbb + Q_W'(prod_bb);
    end
  end

  // the last pair closes the set and clears the sums
  always_comb begin
    sums_nxt = sums_r;
    if (xfer) begin
      sums_nxt = last_pair ? '0 : sums_upd;
    end
  end

  assign push      = xfer && last_pair;
  assign push_sums = sums_upd;

  // sum registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sums_r <= '0;
    end else begin
      sums_r <= sums_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sums_r.n <= N_W'(MAX_PAIRS))
    else $error("pair count beyond set limit");
`endif

endmodule

// ----- hw/rtl/pcc_fifo.sv -----
// two-entry queue of finished sum sets between front and back
module pcc_fifo import pcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  pcc_sums_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      valid,
  output pcc_sums_t data
);

  pcc_sums_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   fill_r;

  assign full  = fill_r == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign valid = fill_r != '0;
  assign data  = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers wrap at the depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/pcc_back.sv -----
// back end: variances and numerator on a shared multiplier, then a bit-serial
// rounded square-root quotient, and the result register
module pcc_back import pcc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             snap_valid,
  input  pcc_sums_t        snap_data,
  output logic             snap_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_corr,
  output logic             out_flag
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_INIT, S_TRY, S_CMP, S_OUT} state_t;

  // multiplier schedule; each product is registered and used at the step after it is issued
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STP_NSAA = 4'd0;
  localparam logic [STEP_W-1:0] STP_SASA = 4'd1;
  localparam logic [STEP_W-1:0] STP_NSBB = 4'd2;
  localparam logic [STEP_W-1:0] STP_SBSB = 4'd3;
  localparam logic [STEP_W-1:0] STP_NSAB = 4'd4;
  localparam logic [STEP_W-1:0] STP_SASB = 4'd5;
  localparam logic [STEP_W-1:0] STP_P0   = 4'd6;
  localparam logic [STEP_W-1:0] STP_P1   = 4'd7;
  localparam logic [STEP_W-1:0] STP_P2   = 4'd8;
  localparam logic [STEP_W-1:0] STP_P3   = 4'd9;
  localparam logic [STEP_W-1:0] STP_M0   = 4'd10;
  localparam logic [STEP_W-1:0] STP_M1   = 4'd11;
  localparam logic [STEP_W-1:0] STP_M2   = 4'd12;
  localparam logic [STEP_W-1:0] STP_M3   = 4'd13;
  localparam logic [STEP_W-1:0] STP_END  = 4'd14;

  // left shift of one partial product of a split square or product
  function automatic int part_shift(input logic [1:0] j);
    case (j)
      2'd0:    part_shift = 0;
      2'd3:    part_shift = 2 * HALF_W;
      default: part_shift = HALF_W;
    endcase
  endfunction

  state_t                 state_r;
  logic [STEP_W-1:0]      step_r;
  pcc_sums_t              snap_r;
  logic [MUL_W-1:0]       mul_a, mul_b;
  logic [PP_W-1:0]        pp_r;
  logic [V_W-1:0]         pp_lo;
  logic [V_W-1:0]         x_r, va_r, vb_r, mag_r;
  logic                   neg_r;
  logic [P_W-1:0]         p_r, m_r;
  logic signed [E_W-1:0]  e_r, mp_r, t_r, cand, p_ext, m_ext;
  logic [K_W-1:0]         k_r;
  logic [BIT_W-1:0]       bit_r, sh;
  logic                   undef;
  logic                   out_valid_r, out_flag_r;
  logic [OUT_W-1:0]       out_corr_r;

  assign snap_pop = (state_r == S_IDLE) && snap_valid;
  assign pp_lo    = pp_r[V_W-1:0];
  assign p_ext    = E_W'(p_r);
  assign m_ext    = E_W'(m_r);
  assign sh       = bit_r + BIT_W'(1);
  assign undef    = (va_r == '0) || (vb_r == '0);
  assign cand     = e_r - (t_r <<< sh);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      STP_NSAA: begin mul_a = MUL_W'(snap_r.n);  mul_b = MUL_W'(snap_r.saa); end
      STP_SASA: begin mul_a = MUL_W'(snap_r.sa); mul_b = MUL_W'(snap_r.sa);  end
      STP_NSBB: begin mul_a = MUL_W'(snap_r.n);  mul_b = MUL_W'(snap_r.sbb); end
      STP_SBSB: begin mul_a = MUL_W'(snap_r.sb); mul_b = MUL_W'(snap_r.sb);  end
      STP_NSAB: begin mul_a = MUL_W'(snap_r.n);  mul_b = MUL_W'(snap_r.sab); end
      STP_SASB: begin mul_a = MUL_W'(snap_r.sa); mul_b = MUL_W'(snap_r.sb);  end
      STP_P0: begin
        mul_a = MUL_W'(va_r[HALF_W-1:0]);
        mul_b = MUL_W'(vb_r[HALF_W-1:0]);
      end
      STP_P1: begin
        mul_a = MUL_W'(va_r[HALF_W-1:0]);
        mul_b = MUL_W'(vb_r[V_W-1:HALF_W]);
      end
      STP_P2: begin
        mul_a = MUL_W'(va_r[V_W-1:HALF_W]);
        mul_b = MUL_W'(vb_r[HALF_W-1:0]);
      end
      STP_P3: begin
        mul_a = MUL_W'(va_r[V_W-1:HALF_W]);
        mul_b = MUL_W'(vb_r[V_W-1:HALF_W]);
      end
      STP_M0: begin
        mul_a = MUL_W'(mag_r[HALF_W-1:0]);
        mul_b = MUL_W'(mag_r[HALF_W-1:0]);
      end
      STP_M1: begin
        mul_a = MUL_W'(mag_r[HALF_W-1:0]);
        mul_b = MUL_W'(mag_r[V_W-1:HALF_W]);
      end
      STP_M2: begin
        mul_a = MUL_W'(mag_r[V_W-1:HALF_W]);
        mul_b = MUL_W'(mag_r[HALF_W-1:0]);
      end
      STP_M3: begin
        mul_a = MUL_W'(mag_r[V_W-1:HALF_W]);
        mul_b = MUL_W'(mag_r[V_W-1:HALF_W]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer, datapath registers and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a taken result frees the register unless the next one loads now
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (snap_valid) begin
            snap_r  <= snap_data;
            step_r  <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          pp_r <= mul_a * mul_b;
          // use the product issued in the previous step
          case (step_r) inside
            STP_SASA: x_r  <= pp_lo;
            STP_NSBB: va_r <= x_r - pp_lo;
            STP_SBSB: x_r  <= pp_lo;
            STP_NSAB: vb_r <= x_r - pp_lo;
            STP_SASB: x_r  <= pp_lo;
            STP_P0: begin
              neg_r <= x_r < pp_lo;
              mag_r <= (x_r < pp_lo) ? (pp_lo - x_r) : (x_r - pp_lo);
              p_r   <= '0;
              m_r   <= '0;
            end
            [STP_P1:STP_M0]: p_r <= p_r + (P_W'(pp_r) << part_shift(2'(step_r - STP_P1)));
            [STP_M1:STP_END]: m_r <= m_r + (P_W'(pp_r) << part_shift(2'(step_r - STP_M1)));
            default: ;
          endcase
          step_r <= step_r + STEP_W'(1);
          if (step_r == STP_END) begin
            state_r <= S_INIT;
          end
        end
        S_INIT: begin
          // residue for k = 0 (odd multiplier -1): target minus one product
          e_r     <= (m_ext <<< TSH) - p_ext;
          mp_r    <= -p_ext;
          k_r     <= '0;
          bit_r   <= BIT_W'(QF);
          state_r <= S_TRY;
        end
        S_TRY: begin
          t_r     <= (mp_r <<< 1) + (p_ext <<< sh);
          state_r <= S_CMP;
        end
        S_CMP: begin
          // keep the bit when the squared odd multiple still fits
          if (!cand[E_W-1]) begin
            e_r  <= cand;
            mp_r <= mp_r + (p_ext <<< sh);
            k_r  <= k_r | (K_W'(1) << bit_r);
          end
          if (bit_r == '0) begin
            state_r <= S_OUT;
          end else begin
            bit_r   <= bit_r - BIT_W'(1);
            state_r <= S_TRY;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_flag_r  <= undef;
            if (undef) begin
              out_corr_r <= '0;
            end else if (neg_r) begin
              out_corr_r <= OUT_W'(0) - OUT_W'(k_r);
            end else begin
              out_corr_r <= OUT_W'(k_r);
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_corr  = out_corr_r;
  assign out_flag  = out_flag_r;

`ifndef SYNTHESIS
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_flag_r |-> out_corr_r == '0)
    else $error("flagged result with nonzero correlation");
  a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed(out_corr_r) <= ONE_Q && $signed(out_corr_r) >= -ONE_Q))
    else $error("correlation outside unit range");
  a_pop_start: assert property (@(posedge clk) disable iff (!rst_n)
    snap_pop |=> state_r == S_MUL && step_r == '0)
    else $error("set taken from queue without starting the schedule");
`endif

endmodule
